// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define DSDW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DSDW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dsdw_pkg.sv
package dsdw_pkg;

  localparam int NUMBER_W       = 32;
  localparam int CODE_W         = 4;
  localparam int ADDR_W         = 4;
  localparam int SEG_W          = 8;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 8;
  localparam int DEF_MAX_DIGITS = 8;

  // x / 10 == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [NUMBER_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int                  RECIP_SHIFT = 35;

  localparam logic [CODE_W-1:0] BLANK_CODE = 4'hF;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECODE_MASK = 1'b1;

  localparam logic [ADDR_W-1:0] RST_DIGIT_COUNT = 4'd8;
  localparam logic [SEG_W-1:0]  RST_DECODE_MASK = 8'h00;

  function automatic logic [SEG_W-1:0] seg_font(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:    seg = 8'b0111_1110;
      4'd1:    seg = 8'b0011_0000;
      4'd2:    seg = 8'b0110_1101;
      4'd3:    seg = 8'b0111_1001;
      4'd4:    seg = 8'b0011_0011;
      4'd5:    seg = 8'b0101_1011;
      4'd6:    seg = 8'b0101_1111;
      4'd7:    seg = 8'b0111_0000;
      4'd8:    seg = 8'b0111_1111;
      4'd9:    seg = 8'b0111_1011;
      default: seg = 8'b0000_0000;  // blank and unused codes
    endcase
    return seg;
  endfunction

endpackage

// File: rtl/core/dsdw_num_if.sv
interface dsdw_num_if import dsdw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// File: rtl/core/dsdw_digit_if.sv
interface dsdw_digit_if import dsdw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] digit_address;
  logic [SEG_W-1:0]  segment_data;
  logic              last;

  modport source (output valid, output digit_address, output segment_data, output last,
                  input ready);
  modport sink   (input valid, input digit_address, input segment_data, input last,
                  output ready);
endinterface

// File: rtl/core/dsdw_cell.sv
module dsdw_cell import dsdw_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS,
  parameter int INDEX      = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic [NUMBER_W-1:0]               up_quot,
  input  logic [MAX_DIGITS-1:0][CODE_W-1:0] up_codes,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic [NUMBER_W-1:0]               dn_quot,
  output logic [MAX_DIGITS-1:0][CODE_W-1:0] dn_codes
);

  logic [2*NUMBER_W-1:0]             prod;
  logic [NUMBER_W-1:0]               quot;
  logic [NUMBER_W-1:0]               rem;
  logic [CODE_W-1:0]                 code;
  logic [MAX_DIGITS-1:0][CODE_W-1:0] codes_next;

  always_comb begin
    prod = {{NUMBER_W{1'b0}}, up_quot} * {{NUMBER_W{1'b0}}, RECIP10};
    quot = NUMBER_W'(prod >> RECIP_SHIFT);
    rem  = up_quot - ((quot << 3) + (quot << 1));
    // leading zeros go blank; the lowest position always shows its digit
    if (INDEX == 0 || up_quot != '0) begin
      code = rem[CODE_W-1:0];
    end else begin
      code = BLANK_CODE;
    end
    codes_next        = up_codes;
    codes_next[INDEX] = code;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_quot  <= quot;
      dn_codes <= codes_next;
    end
  end

endmodule

// File: rtl/core/dsdw_emit.sv
module dsdw_emit import dsdw_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic [MAX_DIGITS-1:0][CODE_W-1:0] up_codes,
  input  logic [ADDR_W-1:0]                 pos_count,
  input  logic [SEG_W-1:0]                  decode_mask,
  dsdw_digit_if.source                      digit_chan
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                              busy;
  logic [ADDR_W-1:0]                 pos;
  logic [MAX_DIGITS-1:0][CODE_W-1:0] codes;
  logic [ADDR_W-1:0]                 count_sat;
  logic [ADDR_W-1:0]                 pos_m1;
  logic [CODE_W-1:0]                 code;
  logic                              raw;
  logic                              load;
  logic                              xfer;

  always_comb begin
    count_sat = (pos_count > ADDR_W'(MAX_DIGITS)) ? ADDR_W'(MAX_DIGITS) : pos_count;
    pos_m1    = pos - 1'b1;
    code      = codes[pos_m1[IDX_W-1:0]];
    raw       = decode_mask[pos_m1[2:0]];
  end

  assign xfer     = busy && digit_chan.ready;
  assign up_ready = !busy || (digit_chan.ready && pos == ADDR_W'(1));
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= (count_sat != '0);  // a count of zero writes nothing
    end else if (xfer && pos == ADDR_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos   <= count_sat;
      codes <= up_codes;
    end else if (xfer) begin
      pos <= pos_m1;
    end
  end

  assign digit_chan.valid         = busy;
  assign digit_chan.digit_address = pos;
  assign digit_chan.last          = (pos == ADDR_W'(1));
  assign digit_chan.segment_data  = raw ? {{(SEG_W-CODE_W){1'b0}}, code} : seg_font(code);

endmodule

// File: rtl/core/decimal_seven_segment_digit_writer.sv
// Channel      Role     Payload
// number_chan  sink     number[31:0]
// digit_chan   source   digit_address[3:0], segment_data[7:0], last
// cfg_*        write    cfg_index 0 position count, 1 decode_mask
//
// A number passes through the cell row, one registered divide-by-ten
// multiplier per cell, into the output stage. It then holds the output stage
// for one write per position of the position count (clamped to MAX_DIGITS),
// and the next number loads in the cycle of the last write; the row can take
// further numbers while the output stage writes. Reset (rst, synchronous)
// empties the row and output stage, count = 8, decode_mask = 0. A stalled
// output backs ready up through the row.
module decimal_seven_segment_digit_writer import dsdw_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  dsdw_num_if.sink               number_chan,
  dsdw_digit_if.source           digit_chan
);

  logic [ADDR_W-1:0] pos_count;
  logic [SEG_W-1:0]  decode_mask;

  logic [MAX_DIGITS:0]               stg_valid;
  logic [MAX_DIGITS:0]               stg_ready;
  logic [NUMBER_W-1:0]               stg_quot  [MAX_DIGITS+1];
  logic [MAX_DIGITS-1:0][CODE_W-1:0] stg_codes [MAX_DIGITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count   <= RST_DIGIT_COUNT;
      decode_mask <= RST_DECODE_MASK;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIGIT_COUNT: pos_count   <= cfg_data[ADDR_W-1:0];
        CFG_DECODE_MASK: decode_mask <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign stg_valid[0]      = number_chan.valid;
  assign number_chan.ready = stg_ready[0];
  assign stg_quot[0]       = number_chan.number;
  assign stg_codes[0]      = '0;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    dsdw_cell #(
      .MAX_DIGITS (MAX_DIGITS),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .up_quot  (stg_quot[i]),
      .up_codes (stg_codes[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_ready[i+1]),
      .dn_quot  (stg_quot[i+1]),
      .dn_codes (stg_codes[i+1])
    );
  end

  dsdw_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (stg_valid[MAX_DIGITS]),
    .up_ready    (stg_ready[MAX_DIGITS]),
    .up_codes    (stg_codes[MAX_DIGITS]),
    .pos_count   (pos_count),
    .decode_mask (decode_mask),
    .digit_chan  (digit_chan)
  );

endmodule

// File: rtl/core/dsdw_checker.sv
`include "assert_macros.svh"

module dsdw_checker import dsdw_pkg::*; #(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] digit_address,
  input logic [SEG_W-1:0]  segment_data,
  input logic              last
);

  `DSDW_ASSERT_ALWAYS(a_idle_after_reset, (rst |=> !out_valid), "output valid after reset")

  `DSDW_ASSERT(a_hold_on_stall,
    ((out_valid && !out_ready) |=> (out_valid && $stable(digit_address) &&
      $stable(segment_data) && $stable(last))), "stalled digit write changed")

  `DSDW_ASSERT(a_addr_range,
    (out_valid |-> (digit_address != '0 && digit_address <= ADDR_W'(MAX_DIGITS))),
    "digit address out of range")

  `DSDW_ASSERT(a_last_on_first_pos,
    (out_valid |-> (last == (digit_address == ADDR_W'(1)))), "last flag not on position 1")

  `DSDW_ASSERT(a_addr_descends,
    ((out_valid && out_ready && !last) |=>
      (out_valid && digit_address == $past(digit_address) - 1'b1)),
    "digit positions not descending")

endmodule

bind decimal_seven_segment_digit_writer dsdw_checker #(
  .MAX_DIGITS (MAX_DIGITS)
) u_dsdw_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (digit_chan.valid),
  .out_ready     (digit_chan.ready),
  .digit_address (digit_chan.digit_address),
  .segment_data  (digit_chan.segment_data),
  .last          (digit_chan.last)
);
